[hdl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // input action codes
  localparam logic ACT_APPEND   = 1'b0;
  localparam logic ACT_FINALIZE = 1'b1;

  // byte positions inside a 64-byte block, the pad byte value, and the last round, word and length-byte indices
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [1:0] LAST_WORD = 2'd3;
  localparam logic [2:0] LEN_MSB   = 3'd7;

  // source of the byte pushed into the block window
  typedef enum logic [1:0] {
    PUSH_DATA,
    PUSH_PAD,
    PUSH_ZERO,
    PUSH_LEN
  } push_sel_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic        push;
    push_sel_t   sel;
    logic [2:0]  len_idx;
    logic        len_incr;
    logic        round_en;
    logic [5:0]  rnd;
    logic        add_en;
    logic        clear;
    logic [1:0]  word_idx;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [5:0] byte_count;
  } dp_sts_t;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // message schedule sigma functions
  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // compression round sigma functions
  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

[hdl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with padding on finalize and a four-word digest.
//
//   channel  | ports                                    | moves
//   ---------+------------------------------------------+-----------------------
//   input    | in_valid in_ready in_action in_data_byte | append byte / finalize
//   output   | out_valid out_ready out_digest_word      | digest words, out_last
//            | out_last                                 | set on the fourth
//
// An append transaction that fills a block also runs the 64 rounds of the
// single round unit and then the feed-forward add.
// A finalize pushes the pad bytes (9 to 72, with an idle step at byte 56),
// runs the rounds and the add for each block it completes, then presents
// the digest one word per handshake as the output side takes it.
// Reset is synchronous; afterwards the block accepts input at once.
// Input is held off while padding, while rounds run and while the digest is
// being delivered.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic        out_last
);
  import sha256_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // hash datapath
  sha256_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_byte    (in_data_byte),
    .out_digest_word (out_digest_word),
    .out_last        (out_last)
  );

endmodule

[hdl/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte loading, padding, 64 compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  output logic                out_valid,
  input  logic                out_ready,
  output sha256_pkg::dp_cmd_t cmd,
  input  sha256_pkg::dp_sts_t sts
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_ZERO,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] len_idx_r, len_idx_nxt;
  logic [1:0] word_idx_r, word_idx_nxt;
  logic       last_byte;

  assign last_byte = (sts.byte_count == LAST_BYTE);

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    rnd_nxt      = rnd_r;
    len_idx_nxt  = len_idx_r;
    word_idx_nxt = word_idx_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.sel      = PUSH_DATA;
    cmd.len_idx  = len_idx_r;
    cmd.rnd      = rnd_r;
    cmd.word_idx = word_idx_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_APPEND) begin
            cmd.push     = 1'b1;
            cmd.sel      = PUSH_DATA;
            cmd.len_incr = 1'b1;
            if (last_byte) begin
              state_nxt = S_ROUND;
              ret_nxt   = S_IDLE;
              rnd_nxt   = '0;
            end
          end else begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.push  = 1'b1;
        cmd.sel   = PUSH_PAD;
        state_nxt = S_ZERO;
        if (last_byte) begin
          state_nxt = S_ROUND;
          ret_nxt   = S_ZERO;
          rnd_nxt   = '0;
        end
      end
      S_ZERO: begin
        if (sts.byte_count == LEN_START) begin
          state_nxt   = S_LEN;
          len_idx_nxt = LEN_MSB;
        end else begin
          cmd.push = 1'b1;
          cmd.sel  = PUSH_ZERO;
          if (last_byte) begin
            state_nxt = S_ROUND;
            ret_nxt   = S_ZERO;
            rnd_nxt   = '0;
          end
        end
      end
      S_LEN: begin
        // length bytes, most significant first; the last one fills the block
        cmd.push    = 1'b1;
        cmd.sel     = PUSH_LEN;
        len_idx_nxt = len_idx_r - 3'd1;
        if (last_byte) begin
          state_nxt    = S_ROUND;
          ret_nxt      = S_OUT;
          rnd_nxt      = '0;
          word_idx_nxt = '0;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_en = 1'b1;
        state_nxt  = ret_r;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          word_idx_nxt = word_idx_r + 2'd1;
          if (word_idx_r == LAST_WORD) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and sequencing counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      rnd_r      <= '0;
      len_idx_r  <= '0;
      word_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      rnd_r      <= rnd_nxt;
      len_idx_r  <= len_idx_nxt;
      word_idx_r <= word_idx_nxt;
    end
  end

endmodule

[hdl/sha256_dp.sv]
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: block window and message schedule, round unit, hash state, length.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sha256_pkg::dp_cmd_t cmd,
  output sha256_pkg::dp_sts_t sts,
  input  logic [7:0]          in_data_byte,
  output logic [63:0]         out_digest_word,
  output logic                out_last
);
  import sha256_pkg::*;

  logic [511:0] win_r, win_nxt;
  logic [31:0]  hash_r [8];
  logic [31:0]  work_r [8];
  logic [5:0]   byte_count_r;
  logic [63:0]  bit_length_r;
  logic [7:0]   push_byte;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2, ch, maj;

  assign sts.byte_count = byte_count_r;

  // byte source select
  always_comb begin
    case (cmd.sel)
      PUSH_DATA: push_byte = in_data_byte;
      PUSH_PAD:  push_byte = PAD_BYTE;
      PUSH_ZERO: push_byte = 8'h00;
      PUSH_LEN:  push_byte = bit_length_r[{cmd.len_idx, 3'b000} +: 8];
      default:   push_byte = 8'h00;
    endcase
  end

  // schedule window taps, oldest word at the top
  assign w0    = win_r[511:480];
  assign w1    = win_r[479:448];
  assign w9    = win_r[223:192];
  assign w14   = win_r[63:32];
  assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;

  // round function
  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^
               (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + big_sig1(work_r[4]) + ch + ROUND_K[cmd.rnd] + w0;
  assign t2  = big_sig0(work_r[0]) + maj;

  always_comb begin
    win_nxt = win_r;
    if (cmd.push) begin
      win_nxt = {win_r[503:0], push_byte};
    end else if (cmd.round_en) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  // block window, filled byte by byte then shifted a word per round
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.push && byte_count_r == LAST_BYTE) begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= hash_r[i];
      end
    end else if (cmd.round_en) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  // hash state, byte count and message length
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= HASH_IV[i];
      end
      byte_count_r <= '0;
      bit_length_r <= '0;
    end else begin
      if (cmd.add_en) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= hash_r[i] + work_r[i];
        end
      end
      if (cmd.push) begin
        byte_count_r <= byte_count_r + 6'd1;
      end
      if (cmd.len_incr) begin
        bit_length_r <= bit_length_r + 64'd8;
      end
    end
  end

  // digest word select
  always_comb begin
    case (cmd.word_idx)
      2'd0:    out_digest_word = {hash_r[0], hash_r[1]};
      2'd1:    out_digest_word = {hash_r[2], hash_r[3]};
      2'd2:    out_digest_word = {hash_r[4], hash_r[5]};
      default: out_digest_word = {hash_r[6], hash_r[7]};
    endcase
  end

  assign out_last = (cmd.word_idx == LAST_WORD);

endmodule
